// File: design/rasc_pkg.sv
package rasc_pkg;

    // operation codes carried in the input transaction
    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_ADDI = 3'd2;
    localparam logic [2:0] CMD_CMP  = 3'd3;
    localparam logic [2:0] CMD_PASS = 3'd4;

    localparam int CMD_W    = 3;
    localparam int RES_W    = 33;
    localparam int OUT_BITS = 4 * RES_W + 1;
    localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [RES_W-1:0] t_res;

    typedef struct packed {
        logic start;
        t_res x;
        t_res y;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_res q;
        t_res r;
    } t_div_rsp;

endpackage

// File: design/rasc_mul.sv
module rasc_mul #(
    parameter int W = 16
) (
    input  logic                  i_clk,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0] o_p
);

    logic signed [2*W-1:0] r_p;

    // full-width signed product, one result a cycle
    always_ff @(posedge i_clk) begin
        r_p <= (2*W)'(i_a) * (2*W)'(i_b);
    end

    assign o_p = r_p;

endmodule

// File: design/rasc_div.sv
module rasc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rasc_pkg::t_div_req i_req,
    output rasc_pkg::t_div_rsp o_rsp
);
    import rasc_pkg::*;

    localparam int CNT_W = $clog2(RES_W + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [RES_W-1:0]    r_rem;
    logic [RES_W-1:0]    r_quo;
    logic [RES_W-1:0]    r_dmag;
    logic                r_qneg;
    logic                r_rneg;

    logic [RES_W:0]      rem_sh;
    logic [RES_W+1:0]    diff;
    logic                ge;
    logic [RES_W-1:0]    x_mag;
    logic [RES_W-1:0]    y_mag;

    // magnitudes as unsigned, -2^32 maps onto 2^32
    assign x_mag = i_req.x[RES_W-1] ? RES_W'(~i_req.x + RES_W'(1)) : i_req.x;
    assign y_mag = i_req.y[RES_W-1] ? RES_W'(~i_req.y + RES_W'(1)) : i_req.y;

    // restoring step: one quotient bit a cycle, MSB first
    assign rem_sh = {r_rem, r_quo[RES_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dmag};
    assign ge     = !diff[RES_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses for one cycle after the last quotient bit
            r_done <= !i_req.start && r_busy && (r_cnt == CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RES_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quo  <= x_mag;
            r_dmag <= y_mag;
            r_qneg <= i_req.x[RES_W-1] ^ i_req.y[RES_W-1];
            r_rneg <= i_req.x[RES_W-1];
        end else if (r_busy) begin
            r_rem <= ge ? diff[RES_W-1:0] : rem_sh[RES_W-1:0];
            r_quo <= {r_quo[RES_W-2:0], ge};
        end
    end

    // truncating signs: quotient by xor, remainder follows the dividend
    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_qneg ? RES_W'(~r_quo + RES_W'(1)) : r_quo;
    assign o_rsp.r    = r_rneg ? RES_W'(~r_rem + RES_W'(1)) : r_rem;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still iterating");

    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (!r_busy && !r_done))
        else $error("divider restarted before result was taken");

    a_nonzero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (i_req.y != '0))
        else $error("divider started with zero divisor");

endmodule

// File: design/rational_add_sub_compare_reduce.sv
// Channel  Dir  tdata fields, lowest bit up                     Width
// s_axis   in   cmd[3], a_num, a_den, b_num, b_den [W each]     3+4W padded to bytes
// m_axis   out  raw_num, raw_den, red_num, red_den [33 each],   136
//               equal[1], zero pad
//
// One transaction at a time: the raw pair is formed on the shared multiplier (states M0,
// M1, M2, RAW), then the shared divider runs one pass per Euclid step (k steps, k is
// 1..~47) plus two for the final quotients; each pass is started in one state (GCD, QN,
// QD) and its result awaited in the next (GWAIT, QNW, QDW).
// Synchronous active-low reset idles the sequencer and empties the output register.
// The input is taken again as soon as the sequencer idles, even if a result still
// waits in the output register; a stalled output holds the sequencer in its last state.
module rational_add_sub_compare_reduce #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // cmd, a_num, a_den, b_num, b_den from bit 0 up, zero padded
    input  logic [((rasc_pkg::CMD_W + 4*OPERAND_WIDTH + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // raw_num, raw_den, red_num, red_den, equal from bit 0 up, zero padded
    output logic [rasc_pkg::OUT_TW-1:0] o_m_axis_tdata
);
    import rasc_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int XW = (PW > RES_W) ? PW : RES_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_M0    = 4'd1;
    localparam logic [3:0] S_M1    = 4'd2;
    localparam logic [3:0] S_M2    = 4'd3;
    localparam logic [3:0] S_RAW   = 4'd4;
    localparam logic [3:0] S_GCD   = 4'd5;
    localparam logic [3:0] S_GWAIT = 4'd6;
    localparam logic [3:0] S_QN    = 4'd7;
    localparam logic [3:0] S_QNW   = 4'd8;
    localparam logic [3:0] S_QD    = 4'd9;
    localparam logic [3:0] S_QDW   = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0]           r_state;
    logic [3:0]           n_state;

    // captured operands, zero denominators already replaced by one
    logic [CMD_W-1:0]     r_cmd;
    logic signed [W-1:0]  r_an;
    logic signed [W-1:0]  r_ad;
    logic signed [W-1:0]  r_bn;
    logic signed [W-1:0]  r_bd;

    logic signed [PW-1:0] r_p;      // a_num * b_den
    logic signed [PW-1:0] r_q;      // b_num * a_den
    t_res                 r_rn;
    t_res                 r_rd;
    logic                 r_eq;
    t_res                 r_gx;
    t_res                 r_gy;
    t_res                 r_g;
    t_res                 r_qn;
    t_res                 r_qd;

    logic                 r_ovalid;
    logic [OUT_TW-1:0]    r_odata;

    logic                 in_acc;
    logic                 out_acc;
    logic                 out_load;

    logic [CMD_W-1:0]     cmd_in;
    logic signed [W-1:0]  a_num_in;
    logic signed [W-1:0]  a_den_in;
    logic signed [W-1:0]  b_num_in;
    logic signed [W-1:0]  b_den_in;

    logic signed [W-1:0]  mul_a;
    logic signed [W-1:0]  mul_b;
    logic signed [PW-1:0] mul_p;

    logic signed [XW-1:0] p_x;
    logic signed [XW-1:0] q_x;
    logic signed [XW-1:0] d_x;
    t_res                 p33;
    t_res                 q33;
    t_res                 d33;
    t_res                 an33;
    t_res                 ad33;
    t_res                 raw_rn;
    t_res                 raw_rd;
    logic                 raw_eq;

    t_div_req             div_req;
    t_div_rsp             div_rsp;

    // ---------------- input side
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    assign cmd_in   = i_s_axis_tdata[CMD_W-1:0];
    assign a_num_in = i_s_axis_tdata[CMD_W       +: W];
    assign a_den_in = i_s_axis_tdata[CMD_W + W   +: W];
    assign b_num_in = i_s_axis_tdata[CMD_W + 2*W +: W];
    assign b_den_in = i_s_axis_tdata[CMD_W + 3*W +: W];

    // ---------------- shared multiplier: an*bd, bn*ad, ad*bd on successive cycles
    always_comb begin
        unique case (r_state)
            S_M0: begin
                mul_a = r_an;
                mul_b = r_bd;
            end
            S_M1: begin
                mul_a = r_bn;
                mul_b = r_ad;
            end
            default: begin
                mul_a = r_ad;
                mul_b = r_bd;
            end
        endcase
    end

    rasc_mul #(
        .W (W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // ---------------- raw pair, everything wraps to 33 bits
    assign p_x  = XW'(r_p);
    assign q_x  = XW'(r_q);
    assign d_x  = XW'(mul_p);
    assign p33  = p_x[RES_W-1:0];
    assign q33  = q_x[RES_W-1:0];
    assign d33  = d_x[RES_W-1:0];
    assign an33 = RES_W'(r_an);
    assign ad33 = RES_W'(r_ad);

    always_comb begin
        raw_eq = 1'b0;
        unique case (r_cmd)
            CMD_ADD: begin
                raw_rn = p33 + q33;
                raw_rd = d33;
            end
            CMD_SUB: begin
                raw_rn = p33 - q33;
                raw_rd = d33;
            end
            CMD_ADDI: begin
                raw_rn = an33 + q33;
                raw_rd = ad33;
            end
            default: begin
                // compare, pass and the unused codes return a unchanged
                raw_rn = an33;
                raw_rd = ad33;
                raw_eq = (r_cmd == CMD_CMP) && (r_p == r_q);
            end
        endcase
    end

    // ---------------- shared divider: Euclid remainders, then the two quotients
    always_comb begin
        div_req.start = 1'b0;
        div_req.x     = r_gx;
        div_req.y     = r_gy;
        unique case (r_state)
            S_GCD: begin
                div_req.start = (r_gy != '0);
            end
            S_QN: begin
                div_req.start = 1'b1;
                div_req.x     = r_rn;
                div_req.y     = r_g;
            end
            S_QD: begin
                div_req.start = 1'b1;
                div_req.x     = r_rd;
                div_req.y     = r_g;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    rasc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---------------- sequencer
    assign out_acc  = r_ovalid && i_m_axis_tready;
    assign out_load = (r_state == S_FIN) && (!r_ovalid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = S_M0;
            S_M0:    n_state = S_M1;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_RAW;
            S_RAW:   n_state = S_GCD;
            S_GCD:   n_state = (r_gy == '0) ? S_QN : S_GWAIT;
            S_GWAIT: if (div_rsp.done) n_state = S_GCD;
            S_QN:    n_state = S_QNW;
            S_QNW:   if (div_rsp.done) n_state = S_QD;
            S_QD:    n_state = S_QDW;
            S_QDW:   if (div_rsp.done) n_state = S_FIN;
            S_FIN:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            // a new load wins over the transaction leaving in the same cycle
            r_ovalid <= out_load || (r_ovalid && !out_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= cmd_in;
            r_an  <= a_num_in;
            r_ad  <= (a_den_in == '0) ? W'(1) : a_den_in;
            r_bn  <= b_num_in;
            r_bd  <= (b_den_in == '0) ? W'(1) : b_den_in;
        end
        if (r_state == S_M1) begin
            r_p <= mul_p;
        end
        if (r_state == S_M2) begin
            r_q <= mul_p;
        end
        if (r_state == S_RAW) begin
            r_rn <= raw_rn;
            r_rd <= raw_rd;
            r_eq <= raw_eq;
            r_gx <= raw_rn;
            r_gy <= raw_rd;
        end
        if (r_state == S_GCD && r_gy == '0) begin
            // both raw parts zero only after a wrap: take one
            r_g <= (r_gx == '0) ? RES_W'(1) : r_gx;
        end
        if (r_state == S_GWAIT && div_rsp.done) begin
            r_gx <= r_gy;
            r_gy <= div_rsp.r;
        end
        if (r_state == S_QNW && div_rsp.done) begin
            r_qn <= div_rsp.q;
        end
        if (r_state == S_QDW && div_rsp.done) begin
            r_qd <= div_rsp.q;
        end
        if (out_load) begin
            r_odata <= OUT_TW'({r_eq, r_qd, r_qn, r_rd, r_rn});
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_GWAIT || r_state == S_QNW || r_state == S_QDW))
        else $error("divider result with no pass outstanding");

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QN) |-> (r_g != '0))
        else $error("reduction by zero gcd");

    a_exact_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QNW && div_rsp.done) |-> (div_rsp.r == '0))
        else $error("gcd does not divide the raw numerator");

endmodule
